>>> rtl/cwvef_pkg.sv
// Shared types, constants and the pixel filter function for the vertical edge filter.
package cwvef_pkg;

  localparam int COLUMNS_DEFAULT = 64;
  localparam int ROWS_DEFAULT    = 6;

  // Column index field carried in commands; wide enough for the largest row.
  localparam int COL_MAX_W = 8;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [15:0] PASS_MASK = 16'h7e7e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_LOW    = 2'd2;

  typedef enum logic {
    CMD_WORD,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic                 emit;
    logic                 has_above;
    logic                 cur_sel;
    logic [COL_MAX_W-1:0] col;
    logic [15:0]          word;
  } cmd_t;

  typedef struct packed {
    logic [63:0] table_lower;
    logic [63:0] table_upper;
    logic        emit_low;
  } cfg_t;

  typedef struct packed {
    logic       frame_last;
    logic [7:0] data;
  } out_t;

  function automatic logic [1:0] pixel_at(input logic [15:0] w, input logic [2:0] k);
    logic [3:0] hi;
    hi = {1'b1, k};
    return {w[hi], w[k]};
  endfunction

  function automatic logic [1:0] table_lookup(input logic [1:0] prev, input logic [1:0] next,
                                              input logic [1:0] self, input cfg_t cfg);
    logic [127:0] tbl;
    logic [6:0]   off;
    logic [7:0]   entry;
    tbl   = {cfg.table_upper, cfg.table_lower};
    off   = {prev, next, 3'b000};
    entry = tbl[off +: 8];
    return entry[{self, 1'b0} +: 2];
  endfunction

  function automatic logic [7:0] filter_word(input logic [15:0] cur, input logic has_above,
                                             input logic [15:0] above, input logic has_below,
                                             input logic [15:0] below, input cfg_t cfg);
    logic [15:0] r;
    logic [1:0]  prev;
    logic [1:0]  next;
    logic [1:0]  v;
    r    = cur & PASS_MASK;
    next = pixel_at(cur, 3'd1);
    prev = has_above ? pixel_at(above, 3'd7) : next;
    v    = table_lookup(prev, next, pixel_at(cur, 3'd0), cfg);
    r[0] = v[0];
    r[8] = v[1];
    prev = pixel_at(cur, 3'd6);
    next = has_below ? pixel_at(below, 3'd0) : prev;
    v    = table_lookup(prev, next, pixel_at(cur, 3'd7), cfg);
    r[7]  = v[0];
    r[15] = v[1];
    return cfg.emit_low ? r[7:0] : r[15:8];
  endfunction

endpackage

>>> rtl/column_word_vertical_edge_filter.sv
// Top level: configuration registers, command queue, front and back ends, result queue.
// Path: a column word that completes a result passes the command queue, then the
// row-store read and filter stage registers, then the result queue. Throughput: one
// column word per cycle unless full; a flush holds the back end for its sweep, one
// row-store read per byte, while words behind it wait in the command queue.
// Reset (rst, synchronous): clears counters, queues and table registers; row store unset.
module column_word_vertical_edge_filter import cwvef_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  action,
  input  logic [15:0]           column_word,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte,
  output logic                  frame_last,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  cfg_t                   cfg;
  logic                   cmd_push;
  cmd_t                   cmd_in;
  cmd_t                   cmd_out;
  logic                   cmd_pop;
  logic                   cmd_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  logic                   out_push;
  out_t                   out_in;
  out_t                   out_head;
  logic                   out_full;
  logic [OUT_CNT_W-1:0]   out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TABLE_LOWER: cfg.table_lower <= wr_data;
        CFG_TABLE_UPPER: cfg.table_upper <= wr_data;
        CFG_EMIT_LOW:    cfg.emit_low    <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  cwvef_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .action      (action),
    .column_word (column_word),
    .cmd_full    (full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  cwvef_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .full    (full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  cwvef_back #(
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty && (cmd_count != '0)),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .out_count (out_count),
    .out_push  (out_push),
    .out_item  (out_in)
  );

  cwvef_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_in),
    .rd_en   (pop),
    .rd_data (out_head),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign out_byte   = out_full ? out_head.data : out_head.data;
  assign frame_last = out_head.frame_last;

endmodule

>>> rtl/cwvef_fifo.sv
// Small first-in first-out queue built from registers.
module cwvef_fifo import cwvef_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> rtl/cwvef_front.sv
// Front end: tracks column and row position, drops or classifies items into commands.
module cwvef_front import cwvef_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        action,
  input  logic [15:0] column_word,
  input  logic        cmd_full,
  output logic        cmd_push,
  output cmd_t        cmd
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS + 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row_count;
  logic             accept;
  logic             row_open;

  assign accept   = push && !cmd_full;
  assign row_open = (row_count < ROW_W'(ROWS));

  always_comb begin
    cmd.kind      = action ? CMD_FLUSH : CMD_WORD;
    cmd.emit      = (row_count != '0);
    cmd.has_above = (row_count >= ROW_W'(2));
    cmd.cur_sel   = ~row_count[0];
    cmd.col       = COL_MAX_W'(col);
    cmd.word      = column_word;
    if (action) begin
      // flush only sweeps when a whole row is waiting
      cmd_push = accept && (col == '0) && (row_count != '0);
    end else begin
      cmd_push = accept && row_open;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (action) begin
        col       <= '0;
        row_count <= '0;
      end else if (row_open) begin
        if (col == COL_LAST) begin
          col       <= '0;
          row_count <= row_count + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

endmodule

>>> rtl/cwvef_back.sv
// Back end: two-row store, flush sweep and the filter stage feeding the result queue.
module cwvef_back import cwvef_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  input  cfg_t                 cfg,
  input  logic [OUT_CNT_W-1:0] out_count,
  output logic                 out_push,
  output out_t                 out_item
);

  localparam int COL_W   = $clog2(COLUMNS);
  localparam int SLOTS_W = OUT_CNT_W + 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

  typedef enum logic {
    B_IDLE,
    B_SWEEP
  } state_t;

  state_t state;

  logic [15:0] bank0 [COLUMNS];
  logic [15:0] bank1 [COLUMNS];
  logic [15:0] rd0;
  logic [15:0] rd1;

  logic [COL_W-1:0] sweep_col;
  logic             sweep_sel;
  logic             sweep_above;

  logic             can_issue;
  logic             issue;
  logic [COL_W-1:0] addr;
  logic             mem_we;
  logic             mem_sel;
  logic             i_emit;
  logic             i_last;
  logic             i_above;
  logic             i_below_ok;
  logic             i_cur_sel;
  logic [15:0]      i_below;

  logic             p_valid;
  logic             p_emit;
  logic             p_last;
  logic             p_above;
  logic             p_below_ok;
  logic             p_cur_sel;
  logic [15:0]      p_below;

  logic [15:0]      cur_word;
  logic [15:0]      above_word;

  // keep room in the result queue for the item already in the filter stage
  assign can_issue = (SLOTS_W'(out_count) + SLOTS_W'(p_valid)) < SLOTS_W'(OUT_DEPTH);

  always_comb begin
    cmd_pop    = 1'b0;
    issue      = 1'b0;
    mem_we     = 1'b0;
    mem_sel    = ~cmd.cur_sel;
    addr       = cmd.col[COL_W-1:0];
    i_emit     = cmd.emit;
    i_last     = 1'b0;
    i_above    = cmd.has_above;
    i_below_ok = 1'b1;
    i_cur_sel  = cmd.cur_sel;
    i_below    = cmd.word;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && can_issue) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_WORD) begin
            issue  = 1'b1;
            mem_we = 1'b1;
          end
        end
      end
      B_SWEEP: begin
        addr       = sweep_col;
        i_emit     = 1'b1;
        i_last     = (sweep_col == COL_LAST);
        i_above    = sweep_above;
        i_below_ok = 1'b0;
        i_cur_sel  = sweep_sel;
        i_below    = '0;
        issue      = can_issue;
      end
      default: begin
      end
    endcase
  end

  // read returns the old word when the same slot is written in that cycle
  always_ff @(posedge clk) begin
    if (mem_we && !mem_sel) begin
      bank0[addr] <= i_below;
    end
    rd0 <= bank0[addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we && mem_sel) begin
      bank1[addr] <= i_below;
    end
    rd1 <= bank1[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue;
      unique case (state)
        B_IDLE: begin
          if (cmd_pop && cmd.kind == CMD_FLUSH) begin
            state <= B_SWEEP;
          end
        end
        B_SWEEP: begin
          if (issue && i_last) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
    if (state == B_IDLE) begin
      sweep_col   <= '0;
      sweep_sel   <= cmd.cur_sel;
      sweep_above <= cmd.has_above;
    end else if (issue) begin
      sweep_col <= sweep_col + COL_W'(1);
    end
    p_emit     <= i_emit;
    p_last     <= i_last;
    p_above    <= i_above;
    p_below_ok <= i_below_ok;
    p_cur_sel  <= i_cur_sel;
    p_below    <= i_below;
  end

  assign cur_word   = p_cur_sel ? rd1 : rd0;
  assign above_word = p_cur_sel ? rd0 : rd1;

  assign out_push            = p_valid && p_emit;
  assign out_item.frame_last = p_last;
  assign out_item.data       = filter_word(cur_word, p_above, above_word,
                                           p_below_ok, p_below, cfg);

endmodule

>>> rtl/cwvef_checker.sv
// Port-level checks for the vertical edge filter, bound to the top level.
module cwvef_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       frame_last
);

  // after reset, results must first pass both queues and the filter stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty ##1 empty ##1 empty)
    else $error("result shown too soon after reset");

  a_reset_not_full: assert property (@(posedge clk)
    rst |=> !full)
    else $error("input side full right after reset");

  // a waiting result that is not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(frame_last))
    else $error("waiting result changed or vanished");

  // the input side only fills up through a transfer in the cycle before
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("input side became full without a push");

endmodule

bind column_word_vertical_edge_filter cwvef_checker u_cwvef_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_byte   (out_byte),
  .frame_last (frame_last)
);
